/* hdl/aarm_pkg.sv */
// ----------------------------------------------------------------------------
// aarm_pkg: shared types and constants
// Holds the CORDIC arctangent table, fixed widths and the rounding helper.
// ----------------------------------------------------------------------------
package aarm_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int ZW           = 34;     // angle accumulator, 2^-32 turn units
    localparam int CW           = 18;     // cosine / sine in Q2.14 with headroom
    localparam int PW           = 32;     // axis pair product
    localparam int MW           = 51;     // pair product times (1 - cos)
    localparam int SW           = 34;     // axis times sine
    localparam int TW           = 54;     // entry sum in Q.42
    localparam longint GAIN_Q30 = 64'd652032874;
    localparam int ONE_Q14      = 16384;

    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Q.42 sum to saturated Q2.14, half rounds up
    function automatic logic signed [15:0] finish(input logic signed [TW-1:0] t);
        logic signed [TW-1:0] rs;
        logic signed [25:0]   r;
        rs = t + TW'(64'd1 << 27);
        r  = 26'(rs >>> 28);
        if (r > 26'sd32767) begin
            return 16'sh7FFF;
        end else if (r < -26'sd32768) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

endpackage

/* hdl/aarm_if.sv */
// ----------------------------------------------------------------------------
// aarm_if: request and response channels
// Valid/ready channels carrying the axis-angle request and the matrix result.
// ----------------------------------------------------------------------------
interface aarm_req_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic        [15:0] angle_turns;
    modport source (output valid, axis_x, axis_y, axis_z, angle_turns, input ready);
    modport sink   (input valid, axis_x, axis_y, axis_z, angle_turns, output ready);
endinterface

interface aarm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] r11, r12, r13, r21, r22, r23, r31, r32, r33;
    modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                    input ready);
    modport sink   (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                    output ready);
endinterface

/* hdl/aarm_cordic.sv */
// ----------------------------------------------------------------------------
// aarm_cordic: unrolled rotation-mode CORDIC
// One register stage per iteration; a sideband word rides along with each item.
// ----------------------------------------------------------------------------
module aarm_cordic #(
    parameter int NS   = 16,
    parameter int FRAC = 14,
    parameter int XW   = 18,
    parameter int SBW  = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  aarm_pkg::t_pipe_ctl         i_ctl,
    input  logic signed [aarm_pkg::ZW-1:0] i_z,
    input  logic [SBW-1:0]              i_sb,
    output logic                        o_vld,
    output logic signed [XW-1:0]        o_x,
    output logic signed [XW-1:0]        o_y,
    output logic [SBW-1:0]              o_sb
);

    localparam int     RSH  = (FRAC < 30) ? (29 - FRAC) : 0;
    localparam longint X0_L = (aarm_pkg::GAIN_Q30 + ((FRAC < 30) ? (64'd1 << RSH) : 64'd0))
                              >> (30 - FRAC);
    localparam logic signed [XW-1:0] X0 = XW'(X0_L);

    logic                           r_vld [1:NS];
    logic signed [XW-1:0]           r_x   [1:NS];
    logic signed [XW-1:0]           r_y   [1:NS];
    logic signed [aarm_pkg::ZW-1:0] r_z   [1:NS];
    logic [SBW-1:0]                 r_sb  [1:NS];

    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic                           cv;
        logic signed [XW-1:0]           cx, cy, dx, dy;
        logic signed [aarm_pkg::ZW-1:0] cz, at;
        logic [SBW-1:0]                 csb;

        if (i == 0) begin : g_first
            assign cv  = i_ctl.vld;
            assign cx  = X0;
            assign cy  = '0;
            assign cz  = i_z;
            assign csb = i_sb;
        end else begin : g_next
            assign cv  = r_vld[i];
            assign cx  = r_x[i];
            assign cy  = r_y[i];
            assign cz  = r_z[i];
            assign csb = r_sb[i];
        end

        assign dx = cy >>> i;
        assign dy = cx >>> i;
        assign at = $signed({2'b00, aarm_pkg::ATAN_TURNS[i]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[i+1] <= cv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                // rotate toward zero residual angle
                if (!cz[aarm_pkg::ZW-1]) begin
                    r_x[i+1] <= cx - dx;
                    r_y[i+1] <= cy + dy;
                    r_z[i+1] <= cz - at;
                end else begin
                    r_x[i+1] <= cx + dx;
                    r_y[i+1] <= cy - dy;
                    r_z[i+1] <= cz + at;
                end
                r_sb[i+1] <= csb;
            end
        end
    end

    assign o_vld = r_vld[NS];
    assign o_x   = r_x[NS];
    assign o_y   = r_y[NS];
    assign o_sb  = r_sb[NS];

endmodule

/* hdl/axis_angle_rotation_matrix_unit.sv */
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_unit: axis-angle to 3x3 rotation matrix
// Rodrigues form on a fully pipelined CORDIC and multiplier datapath.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request: axis (x, y, z) in signed Q2.14 and the angle
//   as a 16-bit fraction of a full turn. o_rsp returns the nine matrix
//   entries r11..r33 in Q2.14, saturated when a non-unit axis overflows.
//   Each request yields exactly one response, in order.
// Pipeline:
//   One request per cycle while o_rsp is not stalled. From acceptance to
//   o_rsp.valid: one register per CORDIC iteration (the axis pair products
//   are taken alongside the first), then a cos/sin rounding stage, a
//   multiplier stage, and the sum/saturate output register.
// Reset:
//   i_rst_n clears all valid bits; payload registers keep whatever they hold.
// Stall:
//   When o_rsp holds a result that is not taken, the whole pipeline holds and
//   i_req.ready drops; nothing is lost or repeated. A free output register
//   lets the pipeline advance even while its upstream stages are full.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_unit #(
    parameter int CORDIC_STEPS = 16,
    parameter int DATA_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aarm_req_if.sink    i_req,
    aarm_rsp_if.source  o_rsp
);

    localparam int NS   = (CORDIC_STEPS > aarm_pkg::ATAN_ENTRIES) ?
                          aarm_pkg::ATAN_ENTRIES : CORDIC_STEPS;
    localparam int FRAC = DATA_BITS - 2;
    localparam int XW   = DATA_BITS + 2;
    localparam int PW   = aarm_pkg::PW;
    localparam int CW   = aarm_pkg::CW;
    localparam int TW   = aarm_pkg::TW;
    localparam int SBW  = 3 * 16 + 2 + 6 * PW;

    // pipeline advance: the output register is free or being drained
    logic en;
    assign en          = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = en;

    // ---------------- quadrant fold and pair products ----------------
    logic [15:0]                    w_qsum;
    logic [1:0]                     w_q;
    logic [15:0]                    w_resid;
    logic signed [aarm_pkg::ZW-1:0] w_z;
    logic signed [PW-1:0]           w_aa, w_bb, w_cc, w_ab, w_ac, w_bc;
    logic [SBW-1:0]                 w_sb;
    aarm_pkg::t_pipe_ctl            w_ctl;

    assign w_qsum  = i_req.angle_turns + 16'h2000;
    assign w_q     = w_qsum[15:14];
    assign w_resid = i_req.angle_turns - {w_q, 14'd0};
    assign w_z     = {{2{w_resid[15]}}, w_resid, 16'd0};
    assign w_aa    = i_req.axis_x * i_req.axis_x;
    assign w_bb    = i_req.axis_y * i_req.axis_y;
    assign w_cc    = i_req.axis_z * i_req.axis_z;
    assign w_ab    = i_req.axis_x * i_req.axis_y;
    assign w_ac    = i_req.axis_x * i_req.axis_z;
    assign w_bc    = i_req.axis_y * i_req.axis_z;
    assign w_sb    = {i_req.axis_x, i_req.axis_y, i_req.axis_z, w_q,
                      w_aa, w_bb, w_cc, w_ab, w_ac, w_bc};
    assign w_ctl   = '{en: en, vld: i_req.valid};

    logic                 k_vld;
    logic signed [XW-1:0] k_x, k_y;
    logic [SBW-1:0]       k_sb;

    aarm_cordic #(.NS(NS), .FRAC(FRAC), .XW(XW), .SBW(SBW)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_z     (w_z),
        .i_sb    (w_sb),
        .o_vld   (k_vld),
        .o_x     (k_x),
        .o_y     (k_y),
        .o_sb    (k_sb)
    );

    // ---------------- round to Q2.14 and unfold quadrant ----------------
    logic signed [CW-1:0] w_c, w_s, w_cos, w_sin;

    if (FRAC > 14) begin : g_rnd
        localparam logic signed [XW-1:0] RND = XW'(64'd1 << (FRAC - 15));
        assign w_c = CW'((k_x + RND) >>> (FRAC - 14));
        assign w_s = CW'((k_y + RND) >>> (FRAC - 14));
    end else if (FRAC < 14) begin : g_up
        assign w_c = CW'(k_x) <<< (14 - FRAC);
        assign w_s = CW'(k_y) <<< (14 - FRAC);
    end else begin : g_same
        assign w_c = CW'(k_x);
        assign w_s = CW'(k_y);
    end

    always_comb begin
        case (k_sb[6*PW +: 2])
            2'd0: begin
                w_cos = w_c;  w_sin = w_s;
            end
            2'd1: begin
                w_cos = -w_s; w_sin = w_c;
            end
            2'd2: begin
                w_cos = -w_c; w_sin = -w_s;
            end
            default: begin
                w_cos = w_s;  w_sin = -w_c;
            end
        endcase
    end

    logic                 r_cs_vld;
    logic signed [CW-1:0] r_cos, r_sin;
    logic signed [15:0]   r_a, r_b, r_c;
    logic signed [PW-1:0] r_p [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs_vld <= 1'b0;
        end else if (en) begin
            r_cs_vld <= k_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cos <= w_cos;
            r_sin <= w_sin;
            r_a   <= k_sb[SBW-1 -: 16];
            r_b   <= k_sb[SBW-17 -: 16];
            r_c   <= k_sb[SBW-33 -: 16];
            for (int j = 0; j < 6; j++) begin
                r_p[j] <= k_sb[(5-j)*PW +: PW];
            end
        end
    end

    // ---------------- multiply by (1 - cos) and by sin ----------------
    logic signed [CW:0] w_vc;
    assign w_vc = (CW+1)'(aarm_pkg::ONE_Q14) - (CW+1)'(r_cos);

    logic                         r_m_vld;
    logic signed [aarm_pkg::MW-1:0] r_m [6];
    logic signed [aarm_pkg::SW-1:0] r_as, r_bs, r_cs;
    logic signed [CW-1:0]         r_m_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= r_cs_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 6; j++) begin
                r_m[j] <= r_p[j] * w_vc;
            end
            r_as    <= r_a * r_sin;
            r_bs    <= r_b * r_sin;
            r_cs    <= r_c * r_sin;
            r_m_cos <= r_cos;
        end
    end

    // ---------------- sum in Q.42, round, saturate ----------------
    logic signed [TW-1:0] w_c42, w_a42, w_b42, w_k42;
    logic signed [TW-1:0] w_t [9];

    assign w_c42 = TW'(r_m_cos) <<< 28;
    assign w_a42 = TW'(r_as) <<< 14;
    assign w_b42 = TW'(r_bs) <<< 14;
    assign w_k42 = TW'(r_cs) <<< 14;

    // r_m order: aa bb cc ab ac bc
    assign w_t[0] = TW'(r_m[0]) + w_c42;
    assign w_t[1] = TW'(r_m[3]) + w_k42;
    assign w_t[2] = TW'(r_m[4]) - w_b42;
    assign w_t[3] = TW'(r_m[3]) - w_k42;
    assign w_t[4] = TW'(r_m[1]) + w_c42;
    assign w_t[5] = TW'(r_m[5]) + w_a42;
    assign w_t[6] = TW'(r_m[4]) + w_b42;
    assign w_t[7] = TW'(r_m[5]) - w_a42;
    assign w_t[8] = TW'(r_m[2]) + w_c42;

    logic               r_o_vld;
    logic signed [15:0] r_r [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 9; j++) begin
                r_r[j] <= aarm_pkg::finish(w_t[j]);
            end
        end
    end

    assign o_rsp.valid = r_o_vld;
    assign o_rsp.r11   = r_r[0];
    assign o_rsp.r12   = r_r[1];
    assign o_rsp.r13   = r_r[2];
    assign o_rsp.r21   = r_r[3];
    assign o_rsp.r22   = r_r[4];
    assign o_rsp.r23   = r_r[5];
    assign o_rsp.r31   = r_r[6];
    assign o_rsp.r32   = r_r[7];
    assign o_rsp.r33   = r_r[8];

    // ---------------- checks ----------------
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_rsp.valid)
        else $error("response valid right after reset");

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cs_vld |-> (r_cos <= 18'sd16448 && r_cos >= -18'sd16448 &&
                      r_sin <= 18'sd16448 && r_sin >= -18'sd16448))
        else $error("cos/sin out of unit range");

    a_hold_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_m_vld) && $stable(r_cs_vld) && $stable(r_m_cos))
        else $error("pipeline moved during stall");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_vld && en |=> o_rsp.valid)
        else $error("item lost between multiply and output stage");

endmodule
